### hw/rtl/gopd_pkg.sv
// gopd_pkg: shared types, constants and helpers for the glyph outline point decoder
// used by gopd_front, gopd_queue, gopd_back and the top level, no dependencies

package gopd_pkg;

  localparam int RUN_W   = 18;
  localparam int FRAC_W  = 14;
  localparam int PROD_W  = 20;
  localparam int COORD_W = 22;

  localparam logic [RUN_W-1:0] RUN_MAX = 18'h1FFFF;
  localparam logic [RUN_W-1:0] RUN_MIN = 18'h20000;
  localparam logic [15:0] SCALE_ONE = 16'h4000;
  localparam logic [33:0] HALF_ROUND = 34'd8192;

  typedef enum logic [2:0] {
    REG_SCALE_XX      = 3'd0,
    REG_SCALE_YY      = 3'd1,
    REG_SCALE_XY      = 3'd2,
    REG_SCALE_YX      = 3'd3,
    REG_SHIFT_X       = 3'd4,
    REG_SHIFT_Y       = 3'd5,
    REG_OFFSET_SCALED = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] scale_xx;
    logic [15:0] scale_yy;
    logic [15:0] scale_xy;
    logic [15:0] scale_yx;
    logic [15:0] shift_x;
    logic [15:0] shift_y;
    logic        offset_scaled;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               on;
    logic               contour_end;
  } point_t;

  // round-half-up f2dot14 product, floor((v * f + 2^13) / 2^14)
  function automatic logic [PROD_W-1:0] fmul_round(logic [RUN_W-1:0] v, logic [15:0] f);
    logic [33:0] p;
    logic [33:0] r;
    p = {{16{v[RUN_W-1]}}, v} * {{18{f[15]}}, f};
    r = p + HALF_ROUND;
    return r[33:FRAC_W];
  endfunction

  // saturate a 19-bit signed sum to 18 signed bits
  function automatic logic [RUN_W-1:0] sat_run(logic [RUN_W:0] s);
    logic [RUN_W-1:0] r;
    if (s[RUN_W] != s[RUN_W-1]) begin
      r = s[RUN_W] ? RUN_MIN : RUN_MAX;
    end else begin
      r = s[RUN_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] ext_prod(logic [PROD_W-1:0] p);
    return {{(COORD_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

endpackage

### hw/rtl/gopd_front.sv
// gopd_front: running coordinates, saturation and matrix transform pipeline
// depends on gopd_pkg; feeds transformed points into gopd_queue

module gopd_front import gopd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_dx,
  input  logic [15:0] in_dy,
  input  logic        in_on,
  input  logic        in_end,
  input  logic        in_gfirst,
  input  logic        q_full,
  output logic        push,
  output point_t      push_point
);

  logic              adv;
  logic              accept;
  logic [RUN_W-1:0]  running_x;
  logic [RUN_W-1:0]  running_y;
  logic [RUN_W-1:0]  base_x;
  logic [RUN_W-1:0]  base_y;
  logic [RUN_W-1:0]  running_x_next;
  logic [RUN_W-1:0]  running_y_next;

  logic              s1_valid;
  logic [RUN_W-1:0]  s1_x;
  logic [RUN_W-1:0]  s1_y;
  logic              s1_on;
  logic              s1_end;

  logic              s2_valid;
  logic [PROD_W-1:0] pxx, pyx, pxy, pyy;
  logic [PROD_W-1:0] oxx, oyx, oxy, oyy;
  logic              s2_on;
  logic              s2_end;

  logic [COORD_W-1:0] ox;
  logic [COORD_W-1:0] oy;

  assign adv      = !(s2_valid && q_full);
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  assign base_x = in_gfirst ? '0 : running_x;
  assign base_y = in_gfirst ? '0 : running_y;
  assign running_x_next = sat_run({base_x[RUN_W-1], base_x} + {{3{in_dx[15]}}, in_dx});
  assign running_y_next = sat_run({base_y[RUN_W-1], base_y} + {{3{in_dy[15]}}, in_dy});

  always_ff @(posedge clk) begin
    if (rst) begin
      running_x <= '0;
      running_y <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
    end else begin
      if (accept) begin
        running_x <= running_x_next;
        running_y <= running_y_next;
      end
      if (adv) begin
        s1_valid <= accept;
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x   <= running_x_next;
      s1_y   <= running_y_next;
      s1_on  <= in_on;
      s1_end <= in_end;
    end
    if (adv && s1_valid) begin
      pxx   <= fmul_round(s1_x, cfg.scale_xx);
      pyx   <= fmul_round(s1_y, cfg.scale_yx);
      pxy   <= fmul_round(s1_x, cfg.scale_xy);
      pyy   <= fmul_round(s1_y, cfg.scale_yy);
      oxx   <= fmul_round({{2{cfg.shift_x[15]}}, cfg.shift_x}, cfg.scale_xx);
      oyx   <= fmul_round({{2{cfg.shift_y[15]}}, cfg.shift_y}, cfg.scale_yx);
      oxy   <= fmul_round({{2{cfg.shift_x[15]}}, cfg.shift_x}, cfg.scale_xy);
      oyy   <= fmul_round({{2{cfg.shift_y[15]}}, cfg.shift_y}, cfg.scale_yy);
      s2_on  <= s1_on;
      s2_end <= s1_end;
    end
  end

  assign ox = cfg.offset_scaled ? ext_prod(oxx) + ext_prod(oyx)
                                : {{(COORD_W-16){cfg.shift_x[15]}}, cfg.shift_x};
  assign oy = cfg.offset_scaled ? ext_prod(oxy) + ext_prod(oyy)
                                : {{(COORD_W-16){cfg.shift_y[15]}}, cfg.shift_y};

  assign push                   = s2_valid && !q_full;
  assign push_point.x           = ext_prod(pxx) + ext_prod(pyx) + ox;
  assign push_point.y           = ext_prod(pxy) + ext_prod(pyy) + oy;
  assign push_point.on          = s2_on;
  assign push_point.contour_end = s2_end;

endmodule

### hw/rtl/gopd_queue.sv
// gopd_queue: small point queue between front and back
// depends on gopd_pkg for the point type

module gopd_queue import gopd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  point_t push_point,
  output logic   full,
  input  logic   pop,
  output point_t pop_point,
  output logic   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  point_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full      = count == CNT_W'(DEPTH);
  assign empty     = count == '0;
  assign do_pop    = pop && !empty;
  assign pop_point = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_point;
    end
  end

endmodule

### hw/rtl/gopd_back.sv
// gopd_back: contour sequencer, emits stored, current and implied midpoints
// depends on gopd_pkg; drains gopd_queue and owns the output register

module gopd_back import gopd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  point_t             q_point,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] x_half,
  output logic [COORD_W-1:0] y_half,
  output logic               point_on,
  output logic               implied,
  output logic               contour_done,
  output logic               last
);

  point_t     prev_pt;
  point_t     first_pt;
  logic       mid_contour;

  point_t     w_cur;
  point_t     w_prev;
  point_t     w_first;
  logic [3:0] mask;
  logic [3:0] mask_rest;
  logic [3:0] mask_next;

  point_t     fsel;
  logic       emit;

  logic [COORD_W-1:0] sel_x;
  logic [COORD_W-1:0] sel_y;
  logic               sel_on;
  logic               sel_imp;
  logic               sel_done;

  assign emit      = (mask != '0) && (!out_valid || out_ready);
  assign mask_rest = mask & (mask - 4'd1);
  assign pop       = !q_empty && ((mask == '0) || (emit && mask_rest == '0));
  assign fsel      = mid_contour ? first_pt : q_point;

  // outputs: stored point, its midpoint, current point, wrap midpoint
  always_comb begin
    mask_next[0] = mid_contour;
    mask_next[1] = mid_contour && !prev_pt.on && !q_point.on;
    mask_next[2] = q_point.contour_end;
    mask_next[3] = q_point.contour_end && !q_point.on && !fsel.on;
  end

  always_comb begin
    sel_x    = w_cur.x + w_first.x;
    sel_y    = w_cur.y + w_first.y;
    sel_on   = 1'b1;
    sel_imp  = 1'b1;
    sel_done = 1'b1;
    priority if (mask[0]) begin
      sel_x    = {w_prev.x[COORD_W-2:0], 1'b0};
      sel_y    = {w_prev.y[COORD_W-2:0], 1'b0};
      sel_on   = w_prev.on;
      sel_imp  = 1'b0;
      sel_done = 1'b0;
    end else if (mask[1]) begin
      sel_x    = w_prev.x + w_cur.x;
      sel_y    = w_prev.y + w_cur.y;
      sel_done = 1'b0;
    end else if (mask[2]) begin
      sel_x    = {w_cur.x[COORD_W-2:0], 1'b0};
      sel_y    = {w_cur.y[COORD_W-2:0], 1'b0};
      sel_on   = w_cur.on;
      sel_imp  = 1'b0;
      sel_done = !mask[3];
    end else begin
      sel_on = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_contour <= 1'b0;
      mask        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        mid_contour <= !q_point.contour_end;
        mask        <= mask_next;
      end else if (emit) begin
        mask <= mask_rest;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      w_cur   <= q_point;
      w_prev  <= prev_pt;
      w_first <= fsel;
      prev_pt <= q_point;
      if (!mid_contour) begin
        first_pt <= q_point;
      end
    end
    if (emit) begin
      x_half       <= sel_x;
      y_half       <= sel_y;
      point_on     <= sel_on;
      implied      <= sel_imp;
      contour_done <= sel_done;
      last         <= mask_rest == '0;
    end
  end

endmodule

### hw/rtl/glyph_outline_point_decoder.sv
// glyph_outline_point_decoder: top level, config registers and stream ports
// depends on gopd_pkg, gopd_front, gopd_queue and gopd_back
//
// usage
//   s_ words carry one glyph point delta each; m_ words carry output points.
//   a word moves on a rising edge with tvalid and tready both high.
//   the apb port holds the matrix and offset; write it only while idle.
//   each input word yields zero to four output words: the held previous
//   point, an implied midpoint, and at contour end the current point and
//   the wrap midpoint. m_tlast marks the final output word of an input word.
// path and throughput
//   an accepted word passes the running sum, multiply stage, queue write,
//   sequencer and output registers before its first output word is shown.
//   input accepts one word per cycle while the point queue has room;
//   the output port gives one word per cycle while m_tready is high and
//   words are pending, so the input rate falls as input words yield more.
// reset and stall
//   rst clears running coordinates, contour state, the queue and all
//   valids, and loads the identity matrix with no offset.
//   when m_tready is low the output word holds, the queue fills, then
//   s_tready drops until the sequencer drains it.

module glyph_outline_point_decoder import gopd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // delta_x[15:0], delta_y[31:16]
  input  logic        s_tlast,   // contour_end
  input  logic [1:0]  s_tuser,   // on_curve[0], glyph_first[1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // x_half[21:0], y_half[43:22], zero[47:44]
  output logic        m_tlast,   // last
  output logic [2:0]  m_tuser,   // point_on[0], implied[1], contour_done[2]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  logic     q_push;
  point_t   q_in;
  logic     q_full;
  logic     q_pop;
  point_t   q_out;
  logic     q_empty;

  logic [COORD_W-1:0] x_half;
  logic [COORD_W-1:0] y_half;
  logic               point_on;
  logic               implied;
  logic               contour_done;
  logic               last;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_xx      <= SCALE_ONE;
      cfg.scale_yy      <= SCALE_ONE;
      cfg.scale_xy      <= '0;
      cfg.scale_yx      <= '0;
      cfg.shift_x       <= '0;
      cfg.shift_y       <= '0;
      cfg.offset_scaled <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SCALE_XX:      cfg.scale_xx      <= pwdata[15:0];
        REG_SCALE_YY:      cfg.scale_yy      <= pwdata[15:0];
        REG_SCALE_XY:      cfg.scale_xy      <= pwdata[15:0];
        REG_SCALE_YX:      cfg.scale_yx      <= pwdata[15:0];
        REG_SHIFT_X:       cfg.shift_x       <= pwdata[15:0];
        REG_SHIFT_Y:       cfg.shift_y       <= pwdata[15:0];
        REG_OFFSET_SCALED: cfg.offset_scaled <= pwdata[0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SCALE_XX:      prdata = {16'd0, cfg.scale_xx};
      REG_SCALE_YY:      prdata = {16'd0, cfg.scale_yy};
      REG_SCALE_XY:      prdata = {16'd0, cfg.scale_xy};
      REG_SCALE_YX:      prdata = {16'd0, cfg.scale_yx};
      REG_SHIFT_X:       prdata = {16'd0, cfg.shift_x};
      REG_SHIFT_Y:       prdata = {16'd0, cfg.shift_y};
      REG_OFFSET_SCALED: prdata = {31'd0, cfg.offset_scaled};
      default:           prdata = '0;
    endcase
  end

  gopd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_dx      (s_tdata[15:0]),
    .in_dy      (s_tdata[31:16]),
    .in_on      (s_tuser[0]),
    .in_end     (s_tlast),
    .in_gfirst  (s_tuser[1]),
    .q_full     (q_full),
    .push       (q_push),
    .push_point (q_in)
  );

  gopd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_point (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .pop_point  (q_out),
    .empty      (q_empty)
  );

  gopd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_point      (q_out),
    .pop          (q_pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .x_half       (x_half),
    .y_half       (y_half),
    .point_on     (point_on),
    .implied      (implied),
    .contour_done (contour_done),
    .last         (last)
  );

  assign m_tdata = {4'd0, y_half, x_half};
  assign m_tuser = {contour_done, implied, point_on};
  assign m_tlast = last;

endmodule

### hw/rtl/gopd_checker.sv
// gopd_checker: port-level checks on the decoder output stream
// bound to glyph_outline_point_decoder, sees its ports only

module gopd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tlast,
  input logic [2:0]  m_tuser
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // an inserted midpoint is always on the curve
  a_implied_on: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0])
    else $error("implied point not marked on curve");

  // the end of a contour is always the last word of its input
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tlast)
    else $error("contour end without last");

endmodule

bind glyph_outline_point_decoder gopd_checker u_gopd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
